### hdl/wrlm_pkg.sv
// Shared types and constants for the word pattern line matcher.
// No dependencies; imported by word_regex_line_matcher_top.
`timescale 1ns / 1ps

package wrlm_pkg;

  // pattern geometry
  localparam int NUM_TOKENS = 8;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = NUM_TOKENS + 1;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = NUM_TOKENS * CHAR_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CHAR_W-1:0] SPACE_BYTE = 8'h20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_COUNT = 2'd3;

  // one input item
  typedef struct packed {
    logic [CHAR_W-1:0] text_byte;
    logic              end_of_line;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic word_done;
    logic word_hit;
    logic line_done;
    logic line_hit;
  } out_item_t;

endpackage

### hdl/word_regex_line_matcher_top.sv
// Word pattern line matcher: input register, one pass of match logic, result register.
// Depends on wrlm_pkg for item types, register indexes and pattern sizes.
`timescale 1ns / 1ps

// Takes one line byte per item and returns one result item for every item.
// Spaces split words; each word is matched in full against up to eight
// literal or dot tokens, any of them starred, kept as a set of live pattern
// positions. An item is taken every cycle while results are taken; each item
// is held in the input register while the match logic forms its result, which
// is then written to the result register once that register is free. The
// position set update and star closure lie between those registers.
// Configuration writes land at once and must only be made while no item is
// in flight.
module word_regex_line_matcher_top
  import wrlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [CFG_DATA_W-1:0] token_chars_r;
  logic [NUM_TOKENS-1:0] dot_mask_r;
  logic [NUM_TOKENS-1:0] star_mask_r;
  logic [CNT_W-1:0]      token_count_r;

  // pipeline and match state
  logic                  in_valid_r;
  in_item_t              in_data_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;
  logic [POS_W-1:0]      active_r;
  logic [POS_W-1:0]      active_nxt;
  logic                  inside_r;
  logic                  inside_nxt;
  logic                  line_hit_r;
  logic                  line_hit_nxt;

  logic                  stage_go;
  logic [CNT_W-1:0]      used_cnt;
  logic                  is_break;
  logic [POS_W-1:0]      end_set;
  logic                  word_match;
  logic [POS_W-1:0]      start_set;

  // mask of positions 0..n
  function automatic logic [POS_W-1:0] pos_mask(input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] m;
    m = '0;
    for (int i = 0; i < POS_W; i++) begin
      m[i] = (CNT_W'(i) <= n);
    end
    return m;
  endfunction

  // add position k+1 for every live starred token k, chaining upward
  function automatic logic [POS_W-1:0] closure(input logic [POS_W-1:0] set,
                                               input logic [NUM_TOKENS-1:0] star,
                                               input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] s;
    s = set;
    for (int k = 0; k < NUM_TOKENS; k++) begin
      if ((CNT_W'(k) < n) && s[k] && star[k]) begin
        s[k+1] = 1'b1;
      end
    end
    return s & pos_mask(n);
  endfunction

  // step the position set over one word byte
  function automatic logic [POS_W-1:0] step(input logic [POS_W-1:0] set,
                                            input logic [CHAR_W-1:0] c,
                                            input logic [CFG_DATA_W-1:0] chars,
                                            input logic [NUM_TOKENS-1:0] dots,
                                            input logic [NUM_TOKENS-1:0] star,
                                            input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] nx;
    logic             acc;
    nx = '0;
    for (int k = 0; k < NUM_TOKENS; k++) begin
      acc = dots[k] || (chars[k*CHAR_W +: CHAR_W] == c);
      if ((CNT_W'(k) < n) && set[k] && acc) begin
        if (star[k]) begin
          nx[k] = 1'b1;
        end else begin
          nx[k+1] = 1'b1;
        end
      end
    end
    return closure(nx, star, n);
  endfunction

  // handshake: input register moves on when the result register is free
  assign stage_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || stage_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // token count saturates at the slot count
  assign used_cnt = (token_count_r > CNT_W'(NUM_TOKENS)) ? CNT_W'(NUM_TOKENS) : token_count_r;

  // match logic for the item in the input register
  always_comb begin
    is_break   = in_data_r.end_of_line || (in_data_r.text_byte == SPACE_BYTE);
    end_set    = closure(active_r, star_mask_r, used_cnt);
    word_match = end_set[used_cnt];
    start_set  = inside_r ? active_r : closure(POS_W'(1), star_mask_r, used_cnt);

    out_data_nxt = '0;
    active_nxt   = active_r;
    inside_nxt   = inside_r;
    line_hit_nxt = line_hit_r;

    if (is_break) begin
      if (inside_r) begin
        out_data_nxt.word_done = 1'b1;
        out_data_nxt.word_hit  = word_match;
        line_hit_nxt           = line_hit_r || word_match;
      end
      inside_nxt = 1'b0;
      active_nxt = '0;
      if (in_data_r.end_of_line) begin
        out_data_nxt.line_done = 1'b1;
        out_data_nxt.line_hit  = line_hit_r || (inside_r && word_match);
        line_hit_nxt           = 1'b0;
      end
    end else begin
      active_nxt = step(closure(start_set, star_mask_r, used_cnt), in_data_r.text_byte,
                        token_chars_r, dot_mask_r, star_mask_r, used_cnt);
      inside_nxt = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_chars_r <= '0;
      dot_mask_r    <= '0;
      star_mask_r   <= '0;
      token_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOKEN_CHARS: token_chars_r <= cfg_wdata;
        CFG_DOT_MASK:    dot_mask_r    <= cfg_wdata[NUM_TOKENS-1:0];
        CFG_STAR_MASK:   star_mask_r   <= cfg_wdata[NUM_TOKENS-1:0];
        CFG_TOKEN_COUNT: token_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // result register and match state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= '0;
      inside_r    <= 1'b0;
      line_hit_r  <= 1'b0;
    end else begin
      if (stage_go) begin
        out_valid_r <= 1'b1;
        active_r    <= active_nxt;
        inside_r    <= inside_nxt;
        line_hit_r  <= line_hit_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### dv/word_regex_line_matcher_top_tb.sv
// Self-checking testbench for word_regex_line_matcher_top: streams lines of words
// through the block under several pattern settings and handshake mixes.
// Depends on wrlm_pkg and the block itself; nothing else is read.
`timescale 1ns / 1ps

module word_regex_line_matcher_top_tb
  import wrlm_pkg::*;
;

  // tracks the expected match state and checks every result in order
  class word_match_scoreboard;
    logic [CFG_DATA_W-1:0] chars;
    logic [NUM_TOKENS-1:0] dots;
    logic [NUM_TOKENS-1:0] stars;
    logic [CNT_W-1:0]      count;
    logic [POS_W-1:0]      live;
    logic                  in_word;
    logic                  line_seen;
    out_item_t             expected_results[$];
    int errors, results, word_hits, line_hits;

    function new();
      chars = '0;
      dots = '0;
      stars = '0;
      count = '0;
      live = '0;
      in_word = 1'b0;
      line_seen = 1'b0;
      errors = 0;
      results = 0;
      word_hits = 0;
      line_hits = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TOKEN_CHARS: chars = data;
        CFG_DOT_MASK:    dots  = data[NUM_TOKENS-1:0];
        CFG_STAR_MASK:   stars = data[NUM_TOKENS-1:0];
        CFG_TOKEN_COUNT: count = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int tokens_used();
      return (count > NUM_TOKENS) ? NUM_TOKENS : int'(count);
    endfunction

    // add the position after every live starred token, chaining upwards
    function logic [POS_W-1:0] close_stars(logic [POS_W-1:0] s, int n);
      for (int k = 0; k < n; k++)
        if (s[k] && stars[k]) s[k+1] = 1'b1;
      for (int k = 0; k < POS_W; k++)
        if (k > n) s[k] = 1'b0;
      return s;
    endfunction

    // consume one word byte from every live position
    function logic [POS_W-1:0] advance_positions(logic [POS_W-1:0] s, int n,
                                                 logic [CHAR_W-1:0] c);
      logic [POS_W-1:0] nxt;
      nxt = '0;
      for (int k = 0; k < n; k++) begin
        if (s[k] && (dots[k] || chars[CHAR_W*k +: CHAR_W] == c)) begin
          if (stars[k]) nxt[k] = 1'b1;
          else nxt[k+1] = 1'b1;
        end
      end
      return close_stars(nxt, n);
    endfunction

    function void note_item(in_item_t it);
      out_item_t        e;
      int               n;
      logic [POS_W-1:0] s;
      e = '0;
      n = tokens_used();
      if (it.end_of_line || it.text_byte == SPACE_BYTE) begin
        if (in_word) begin
          s = close_stars(live, n);
          e.word_done = 1'b1;
          e.word_hit = s[n];
          if (s[n]) line_seen = 1'b1;
        end
        in_word = 1'b0;
        live = '0;
        if (it.end_of_line) begin
          e.line_done = 1'b1;
          e.line_hit = line_seen;
          line_seen = 1'b0;
        end
      end else begin
        s = in_word ? live : close_stars(POS_W'(1), n);
        live = advance_positions(close_stars(s, n), n, it.text_byte);
        in_word = 1'b1;
      end
      expected_results = {expected_results, e};
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s got %b expected %b", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("result %b with nothing expected", got));
        return;
      end
      e = expected_results.pop_front();
      results++;
      if (e.word_hit) word_hits++;
      if (e.line_hit) line_hits++;
      compare_field("word_done", got.word_done, e.word_done);
      compare_field("word_hit", got.word_hit, e.word_hit);
      compare_field("line_done", got.line_done, e.line_done);
      compare_field("line_hit", got.line_hit, e.line_hit);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  word_match_scoreboard sb;

  // current pattern, used to build words that should match
  logic [CFG_DATA_W-1:0] cur_chars;
  logic [NUM_TOKENS-1:0] cur_dots;
  logic [NUM_TOKENS-1:0] cur_stars;
  logic [CNT_W-1:0]      cur_count;

  logic [CHAR_W-1:0] line_bytes[$];
  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int lines_sent = 0;
  int settings = 0;

  word_regex_line_matcher_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(logic [CHAR_W-1:0] b);
    send_item({b, 1'b0});
  endtask

  // the byte beside a terminator is ignored, so keep it random
  task automatic send_eol();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(255));
    send_item({b, 1'b1});
  endtask

  // let every item in flight come out before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic write_pattern(logic [CFG_DATA_W-1:0] ch, logic [NUM_TOKENS-1:0] dm,
                               logic [NUM_TOKENS-1:0] sm, logic [CNT_W-1:0] cnt);
    drain();
    put_reg(CFG_TOKEN_CHARS, ch);
    put_reg(CFG_DOT_MASK, CFG_DATA_W'(dm));
    put_reg(CFG_STAR_MASK, CFG_DATA_W'(sm));
    put_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(cnt));
    cfg_we <= 1'b0;
    cur_chars = ch;
    cur_dots = dm;
    cur_stars = sm;
    cur_count = cnt;
    settings++;
  endtask

  task automatic random_pattern();
    logic [CFG_DATA_W-1:0] ch;
    logic [CNT_W-1:0]      cnt;
    for (int k = 0; k < NUM_TOKENS; k++) begin
      if ($urandom_range(19) < 14) ch[CHAR_W*k +: CHAR_W] = 8'h61 + CHAR_W'($urandom_range(3));
      else ch[CHAR_W*k +: CHAR_W] = CHAR_W'($urandom_range(255));
    end
    cnt = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(15)) : CNT_W'($urandom_range(1, 8));
    write_pattern(ch, NUM_TOKENS'($urandom_range(255)) & NUM_TOKENS'($urandom_range(255)),
                  NUM_TOKENS'($urandom_range(255)) & NUM_TOKENS'($urandom_range(255)), cnt);
  endtask

  // any byte but a space, often from a small alphabet so literals hit
  function automatic logic [CHAR_W-1:0] word_byte();
    logic [CHAR_W-1:0] b;
    if ($urandom_range(1) == 1) begin
      b = 8'h61 + CHAR_W'($urandom_range(3));
    end else begin
      b = CHAR_W'($urandom_range(255));
      if (b == SPACE_BYTE) b = 8'h00;
    end
    return b;
  endfunction

  // word built from the pattern, sometimes damaged
  function automatic void push_pattern_word();
    int n, reps, start;
    n = (cur_count > NUM_TOKENS) ? NUM_TOKENS : int'(cur_count);
    start = line_bytes.size();
    for (int k = 0; k < n; k++) begin
      reps = cur_stars[k] ? $urandom_range(3) : 1;
      repeat (reps)
        line_bytes = {line_bytes,
                      (cur_dots[k] ? word_byte() : cur_chars[CHAR_W*k +: CHAR_W])};
    end
    if (line_bytes.size() == start || $urandom_range(3) == 0)
      line_bytes = {line_bytes, word_byte()};
    else if ($urandom_range(5) == 0)
      line_bytes[start + $urandom_range(line_bytes.size() - start - 1)] = word_byte();
  endfunction

  function automatic void push_noise_word();
    repeat ($urandom_range(1, 6)) line_bytes = {line_bytes, word_byte()};
  endfunction

  // one line of words; now and then the terminator is left off
  task automatic send_line();
    int words;
    line_bytes.delete();
    if ($urandom_range(3) == 0) line_bytes = {line_bytes, SPACE_BYTE};
    words = $urandom_range(4);
    for (int w = 0; w < words; w++) begin
      if (w > 0) repeat ($urandom_range(1, 2)) line_bytes = {line_bytes, SPACE_BYTE};
      if ($urandom_range(9) < 7) push_pattern_word();
      else push_noise_word();
    end
    if ($urandom_range(4) == 0) line_bytes = {line_bytes, SPACE_BYTE};
    foreach (line_bytes[i]) send_text(line_bytes[i]);
    if ($urandom_range(9) != 0) send_eol();
    lines_sent++;
  endtask

  // run limit
  initial begin
    #2000000;
    $display("Timeout: the block stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    int gap_mix[4];
    int stall_mix[4];
    int mark;
    gap_mix = '{0, 55, 0, 21};
    stall_mix = '{0, 0, 55, 21};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a, starred dot, b: empty line, space runs, extreme bytes, a failing word
    write_pattern(64'h0000_0000_0062_2E61, 8'b010, 8'b010, 4'd3);
    send_eol();
    send_text(SPACE_BYTE);
    send_text(8'h61);
    send_text(8'h62);
    send_text(SPACE_BYTE);
    send_text(SPACE_BYTE);
    send_text(8'h61);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'h62);
    send_eol();
    send_text(8'h61);
    send_eol();

    // empty pattern never matches
    write_pattern('0, '0, '0, '0);
    send_text(8'h78);
    send_eol();

    // oversized count saturates to eight dots
    write_pattern(64'h0123_4567_89AB_CDEF, 8'hFF, 8'h00, 4'hF);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h01);
    send_text(8'h80);
    send_text(8'h7F);
    send_text(8'h0A);
    send_text(8'h41);
    send_text(8'hFE);
    send_eol();

    // random lines under each handshake mix and several patterns
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_mix[ph];
      stall_pct = stall_mix[ph];
      for (int s = 0; s < 3; s++) begin
        if (ph == 0 && s == 0) write_pattern('1, '1, '1, '1);
        else random_pattern();
        mark = items_sent;
        while (items_sent - mark < 36) send_line();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d items (%0d generated lines) over %0d pattern settings and 4 handshake mixes",
             items_sent, lines_sent, settings);
    $display("Checked %0d results: %0d matching words, %0d matching lines",
             sb.results, sb.word_hits, sb.line_hits);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### word_regex_line_matcher_top.f
hdl/wrlm_pkg.sv
hdl/word_regex_line_matcher_top.sv
dv/word_regex_line_matcher_top_tb.sv
